/* hdl/tphg_pkg.sv */
`timescale 1ns / 1ps
package tphg_pkg;
   localparam int MaxRules = 256;
   localparam int MaxFrame = 9000;
   localparam int HdrWords = 27;
   localparam logic [2:0] ADDR_MODE   = 3'd0;
   localparam logic [2:0] ADDR_RCOUNT = 3'd1;
   localparam logic [2:0] ADDR_SEED   = 3'd2;
   localparam logic [2:0] ADDR_DMAC   = 3'd3;
   localparam logic [2:0] ADDR_SMAC   = 3'd4;
   localparam logic [2:0] ADDR_SIP    = 3'd5;
   localparam logic [2:0] ADDR_DIP    = 3'd6;
   localparam logic OP_START = 1'b0;
   localparam logic OP_WORD  = 1'b1;

   typedef struct packed {
      logic start;      // latch frame, begin lcg draws
      logic lcg_step;   // one lcg step
      logic [1:0] draw; // which draw is being stored
      logic add_word;   // absorb payload word
      logic csum_step;  // one checksum accumulation step
      logic [4:0] csum_idx;
      logic [4:0] hidx;
   } cmd_type;

   typedef struct packed {
      logic words_done; // payload counter will reach zero with this word
      logic frame_open;
   } sts_type;

   function automatic logic [15:0] fold_not(input logic [31:0] s);
      logic [31:0] t;
      t = {16'd0, s[31:16]} + {16'd0, s[15:0]};
      t = t + {16'd0, t[31:16]};
      return ~t[15:0];
   endfunction
endpackage

/* hdl/tcp_packet_header_generator.sv */
`timescale 1ns / 1ps
// TCP test frame header generator.
// Input channel req_*: operation 0 starts a frame of req_frame_bytes, 1 delivers
// one 16-bit payload word. Result channel rsp_*: one announcement per start
// (kind 0, from_rule, rule_number), then after the last payload word the 27
// big-endian header words (kind 1, word_index, last on word 26).
// A start runs three LCG steps, each a registered multiply split into two
// 32-bit halves and a draw, then a wait state, before its announcement.
// Each payload word is absorbed on acceptance; the last one is followed by a
// checksum pass over header words 7-26, then one header word per unstalled cycle.
// One item is in work at a time; req_ready is low until all its results are
// transferred. A stalled rsp_ready holds the current result and the block.
// Reset restores all register defaults, zeroes the seed and the LCG, and
// closes any open frame. Registers via csr_ APB port, 8-byte spacing.
module tcp_packet_header_generator (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_operation,
   input  logic [13:0] req_frame_bytes,
   input  logic [15:0] req_payload_word,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_kind,
   output logic rsp_from_rule,
   output logic [7:0] rsp_rule_number,
   output logic [15:0] rsp_header_word,
   output logic [4:0] rsp_word_index,
   output logic rsp_last,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [5:0] csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic csr_pready
);
   import tphg_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic ann_rule;
   logic [7:0] ann_num;
   logic [15:0] hw;

   assign csr_pready = 1'b1;

   tphg_control u_ctl (
      .clock, .reset, .req_valid, .req_ready, .req_operation,
      .rsp_valid, .rsp_ready, .rsp_kind, .rsp_last, .rsp_word_index,
      .sts, .cmd
   );

   tphg_datapath u_dp (
      .clock, .reset, .cmd, .sts,
      .frame_bytes(req_frame_bytes), .payload_word(req_payload_word),
      .cfg_we(csr_psel & csr_penable & csr_pwrite & (csr_paddr[5:3] != 3'd7)
              & (csr_paddr[2:0] == 3'd0)),
      .cfg_addr(csr_paddr[5:3]), .cfg_data(csr_pwdata), .cfg_rdata(csr_prdata),
      .ann_rule, .ann_rule_number(ann_num), .hdr_word(hw)
   );

   assign rsp_from_rule = rsp_kind ? 1'b0 : ann_rule;
   assign rsp_rule_number = rsp_kind ? 8'd0 : ann_num;
   assign rsp_header_word = rsp_kind ? hw : 16'd0;
endmodule

/* hdl/tphg_datapath.sv */
`timescale 1ns / 1ps
module tphg_datapath (
   input  logic clock,
   input  logic reset,
   input  tphg_pkg::cmd_type cmd,
   output tphg_pkg::sts_type sts,
   input  logic [13:0] frame_bytes,
   input  logic [15:0] payload_word,
   input  logic cfg_we,
   input  logic [2:0] cfg_addr,
   input  logic [63:0] cfg_data,
   output logic [63:0] cfg_rdata,
   output logic ann_rule,
   output logic [7:0] ann_rule_number,
   output logic [15:0] hdr_word
);
   import tphg_pkg::*;

   logic [2:0] mode_ff;
   logic [8:0] rcount_ff;
   logic [63:0] seed_ff, lcg_ff, lcg_in, prod_lo_ff;
   logic [31:0] prod_hi_ff;
   logic [47:0] dmac_ff, smac_ff;
   logic [31:0] sip_ff, dip_ff;
   logic [1:0] fcnt_ff;
   logic [7:0] ridx_ff;
   logic [13:0] fsize_ff;
   logic [12:0] left_ff;
   logic [31:0] sum_ff, ipsum_ff, tcpsum_ff;
   logic [15:0] dport_ff;
   logic [31:0] seq_ff, ack_ff;
   logic ann_rule_ff;
   logic [7:0] ann_num_ff;
   logic rule;
   logic [2:0] mode_eff;
   logic [8:0] eff, cur, nxt;
   logic [13:0] fb;
   logic [15:0] w, hw;
   logic [15:0] ipck, tcpck;
   logic [31:0] draw;

   always_comb begin
      mode_eff = (mode_ff > 3'd4) ? 3'd4 : mode_ff;
      case (mode_eff)
         3'd0: rule = 1'b0;
         3'd1: rule = (fcnt_ff == 2'd0);
         3'd2: rule = ~fcnt_ff[0];
         3'd3: rule = (fcnt_ff != 2'd0);
         default: rule = 1'b1;
      endcase
      eff = (rcount_ff == 9'd0) ? 9'd1 : ((rcount_ff > 9'd256) ? 9'd256 : rcount_ff);
      cur = ({1'b0, ridx_ff} < eff) ? {1'b0, ridx_ff} : 9'd0;
      nxt = (cur + 9'd1 == eff) ? 9'd0 : cur + 9'd1;
      fb = (frame_bytes < 14'd60) ? 14'd60 :
           ((frame_bytes > 14'(MaxFrame)) ? 14'(MaxFrame) : frame_bytes);
      w = (left_ff == 13'd1 && fsize_ff[0]) ? {payload_word[15:8], 8'd0} : payload_word;
      lcg_in = {prod_hi_ff + prod_lo_ff[63:32], prod_lo_ff[31:0]} + 64'd12345;
      draw = lcg_in[63:32];
      ipck = fold_not(ipsum_ff);
      tcpck = fold_not(tcpsum_ff);
   end

   function automatic logic [15:0] hword(input logic [4:0] k, input logic [15:0] ic,
                                         input logic [15:0] tc);
      case (k)
         5'd0: return dmac_ff[47:32];
         5'd1: return dmac_ff[31:16];
         5'd2: return dmac_ff[15:0];
         5'd3: return smac_ff[47:32];
         5'd4: return smac_ff[31:16];
         5'd5: return smac_ff[15:0];
         5'd6: return 16'h0800;
         5'd7: return 16'h4500;
         5'd8: return 16'(fsize_ff - 14'd14);
         5'd11: return 16'h2006;
         5'd12: return ic;
         5'd13: return sip_ff[31:16];
         5'd14: return sip_ff[15:0];
         5'd15: return dip_ff[31:16];
         5'd16: return dip_ff[15:0];
         5'd17: return 16'd80;
         5'd18: return dport_ff;
         5'd19: return seq_ff[31:16];
         5'd20: return seq_ff[15:0];
         5'd21: return ack_ff[31:16];
         5'd22: return ack_ff[15:0];
         5'd23: return 16'h5010;
         5'd24: return 16'd5840;
         5'd25: return tc;
         default: return 16'd0;
      endcase
   endfunction

   always_comb hw = hword(cmd.csum_idx, 16'd0, 16'd0);
   assign hdr_word = hword(cmd.hidx, ipck, tcpck);
   assign sts.words_done = (left_ff == 13'd1);
   assign sts.frame_open = (left_ff != 13'd0);
   assign ann_rule = ann_rule_ff;
   assign ann_rule_number = ann_num_ff;

   always_comb begin
      unique case (cfg_addr)
         ADDR_MODE:   cfg_rdata = {61'd0, mode_ff};
         ADDR_RCOUNT: cfg_rdata = {55'd0, rcount_ff};
         ADDR_SEED:   cfg_rdata = seed_ff;
         ADDR_DMAC:   cfg_rdata = {16'd0, dmac_ff};
         ADDR_SMAC:   cfg_rdata = {16'd0, smac_ff};
         ADDR_SIP:    cfg_rdata = {32'd0, sip_ff};
         ADDR_DIP:    cfg_rdata = {32'd0, dip_ff};
         default:     cfg_rdata = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_lo_ff <= 64'(lcg_ff[31:0]) * 64'd1103515245;
      prod_hi_ff <= lcg_ff[63:32] * 32'd1103515245;
      if (reset) begin
         mode_ff <= 3'd4; rcount_ff <= 9'd1; seed_ff <= 64'd0; lcg_ff <= 64'd0;
         dmac_ff <= 48'h000423B729C4; smac_ff <= 48'h000423B721D8;
         sip_ff <= 32'h0A0A0A0A; dip_ff <= 32'h0B0B0B0B;
         fcnt_ff <= 2'd0; ridx_ff <= 8'd0; fsize_ff <= 14'd0; left_ff <= 13'd0;
         sum_ff <= 32'd0; dport_ff <= 16'd0; seq_ff <= 32'd0; ack_ff <= 32'd0;
         ann_rule_ff <= 1'b0; ann_num_ff <= 8'd0;
         ipsum_ff <= 32'd0; tcpsum_ff <= 32'd0;
      end else begin
         if (cfg_we) begin
            unique case (cfg_addr)
               ADDR_MODE:   mode_ff <= cfg_data[2:0];
               ADDR_RCOUNT: rcount_ff <= cfg_data[8:0];
               ADDR_SEED:   begin seed_ff <= cfg_data; lcg_ff <= cfg_data; end
               ADDR_DMAC:   dmac_ff <= cfg_data[47:0];
               ADDR_SMAC:   smac_ff <= cfg_data[47:0];
               ADDR_SIP:    sip_ff <= cfg_data[31:0];
               ADDR_DIP:    dip_ff <= cfg_data[31:0];
               default: ;
            endcase
         end
         if (cmd.start) begin
            fsize_ff <= fb;
            left_ff <= 13'((fb - 14'd53) >> 1);
            sum_ff <= 32'd0;
            ann_rule_ff <= rule;
            ann_num_ff <= rule ? cur[7:0] : 8'd0;
            if (rule) ridx_ff <= nxt[7:0];
            fcnt_ff <= fcnt_ff + 2'd1;
         end
         if (cmd.lcg_step) begin
            lcg_ff <= lcg_in;
            case (cmd.draw)
               2'd0: dport_ff <= {draw[23:16], draw[31:24]};
               2'd1: seq_ff <= {draw[7:0], draw[15:8], draw[23:16], draw[31:24]};
               default: ack_ff <= {draw[7:0], draw[15:8], draw[23:16], draw[31:24]};
            endcase
         end
         if (cmd.add_word) begin
            sum_ff <= sum_ff + {16'd0, w};
            left_ff <= left_ff - 13'd1;
            ipsum_ff <= 32'd0;
            tcpsum_ff <= sum_ff + {16'd0, w} + 32'd6 + {16'd0, 16'(fsize_ff - 14'd34)};
         end
         if (cmd.csum_step) begin
            if (cmd.csum_idx >= 5'd7 && cmd.csum_idx <= 5'd16)
               ipsum_ff <= ipsum_ff + {16'd0, hw};
            if (cmd.csum_idx >= 5'd13)
               tcpsum_ff <= tcpsum_ff + {16'd0, hw};
         end
      end
   end
endmodule

/* hdl/tphg_control.sv */
`timescale 1ns / 1ps
module tphg_control (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_operation,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_kind,
   output logic rsp_last,
   output logic [4:0] rsp_word_index,
   input  tphg_pkg::sts_type sts,
   output tphg_pkg::cmd_type cmd
);
   import tphg_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001, S_MUL = 7'b0000010, S_DRAW = 7'b0000100,
      S_ANN = 7'b0001000, S_CSUM = 7'b0010000, S_HDR = 7'b0100000,
      S_WAIT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] idx_ff, idx_in;
   logic [1:0] draw_ff, draw_in;
   logic acc;

   assign req_ready = (state_ff == S_IDLE);
   assign acc = req_valid & req_ready;
   assign rsp_valid = (state_ff == S_ANN) || (state_ff == S_HDR);
   assign rsp_kind = (state_ff == S_HDR);
   assign rsp_word_index = (state_ff == S_HDR) ? idx_ff : 5'd0;
   assign rsp_last = (state_ff == S_HDR) && (idx_ff == 5'(HdrWords - 1));

   always_comb begin
      state_in = state_ff; idx_in = idx_ff; draw_in = draw_ff;
      cmd = '0;
      cmd.draw = draw_ff;
      cmd.csum_idx = idx_ff;
      cmd.hidx = idx_ff;
      unique case (state_ff)
         S_IDLE: if (acc) begin
            if (req_operation == OP_START) begin
               cmd.start = 1'b1; draw_in = 2'd0; state_in = S_MUL;
            end else if (sts.frame_open) begin
               cmd.add_word = 1'b1;
               if (sts.words_done) begin idx_in = 5'd7; state_in = S_CSUM; end
            end
         end
         S_MUL: state_in = S_DRAW;
         S_DRAW: begin
            cmd.lcg_step = 1'b1;
            draw_in = draw_ff + 2'd1;
            state_in = (draw_ff == 2'd2) ? S_WAIT : S_MUL;
         end
         S_WAIT: state_in = S_ANN;
         S_ANN: if (rsp_ready) state_in = S_IDLE;
         S_CSUM: begin
            cmd.csum_step = 1'b1;
            idx_in = idx_ff + 5'd1;
            if (idx_ff == 5'(HdrWords - 1)) begin idx_in = 5'd0; state_in = S_HDR; end
         end
         S_HDR: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 5'd1;
               if (idx_ff == 5'(HdrWords - 1)) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; idx_ff <= 5'd0; draw_ff <= 2'd0;
      end else begin
         state_ff <= state_in; idx_ff <= idx_in; draw_ff <= draw_in;
      end
   end
endmodule

/* hdl/tphg_checker.sv */
`timescale 1ns / 1ps
module tphg_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_kind,
   input logic rsp_last,
   input logic [4:0] rsp_word_index,
   input logic [15:0] rsp_header_word
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_header_word))
      else $error("result dropped under stall");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> (rsp_last == (rsp_word_index == 5'd26)))
      else $error("last mismatch");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("ready while result pending");
   a_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_kind && !rsp_last |=>
      rsp_valid && rsp_kind && rsp_word_index == $past(rsp_word_index) + 5'd1)
      else $error("header word order");
endmodule

bind tcp_packet_header_generator tphg_checker u_chk (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_kind, .rsp_last, .rsp_word_index, .rsp_header_word
);
